FILE: hdl/hypergeometric_tail_p_value_unit_macros.svh
// Assertion macros shared by the hypergeometric tail unit.
`ifndef HYPERGEOMETRIC_TAIL_P_VALUE_UNIT_MACROS_SVH
`define HYPERGEOMETRIC_TAIL_P_VALUE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define HGT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("hgt: property failed");
// Check that a condition never holds outside reset.
`define HGT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("hgt: forbidden condition seen");
`else
`define HGT_ASSERT(lbl, clk, rst_n, prop)
`define HGT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: hdl/hgt_pkg.sv
`default_nettype none
package hgt_pkg;
	localparam int FIELD_W   = 6;
	localparam int COEF_W    = 60;
	localparam int HALF_W    = 30;
	localparam int FRAC_BITS = 16;
	localparam int P_W       = FRAC_BITS + 1;
	localparam int QDEPTH    = 2;
	localparam logic [P_W-1:0] ONE_FIXED = P_W'(1) << FRAC_BITS;

	typedef logic [FIELD_W-1:0] fld_t;
	typedef logic [COEF_W-1:0]  coef_t;

	// Classified query handed from the front to the back.
	typedef struct packed {
		logic bad;
		logic upper;
		logic none;   // summed range is empty
		fld_t lo;
		fld_t hi;
		fld_t n;
		fld_t m;
		fld_t pop;
	} hgt_desc_t;

	typedef struct packed {
		logic      valid;
		hgt_desc_t desc;
	} hgt_q_out_t;
endpackage
`default_nettype wire

FILE: hdl/hypergeometric_tail_p_value_unit.sv
`default_nettype none
// One-sided hypergeometric tail p-value. After reset the unit fills its
// binomial coefficient store, one entry a cycle, with full held high.
// Each query then sums the terms of the tail: every term needs two reads
// of the single store port and three passes through one shared 30x30
// multiplier, and the final 16-bit quotient comes from a one bit per
// cycle divider. Up to two queries wait in the input queue while one is
// worked; a finished result waits in its output register until popped.
// bad_query flags draws or successes above population, or a population
// of MAX_POP or more (all else zero).
module hypergeometric_tail_p_value_unit #(
	parameter int MAX_POP = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                push,
	output logic                               full,
	input  wire hgt_pkg::fld_t                 threshold,
	input  wire hgt_pkg::fld_t                 draws,
	input  wire hgt_pkg::fld_t                 successes,
	input  wire hgt_pkg::fld_t                 population,
	output logic                               empty,
	input  wire                                pop,
	output logic [hgt_pkg::P_W-1:0]            p_value,
	output logic [hgt_pkg::COEF_W-1:0]         tail_sum,
	output logic [hgt_pkg::COEF_W-1:0]         total_ways,
	output logic                               upper_tail,
	output logic                               bad_query
);
	import hgt_pkg::*;

	hgt_q_out_t head;
	logic       q_full;
	logic       busy;
	logic       deq;

	// Refuse items while the queue is full or the store is still filling.
	assign full = q_full || busy;

	hgt_front #(.MAX_POP(MAX_POP)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.threshold  (threshold),
		.draws      (draws),
		.successes  (successes),
		.population (population),
		.accept     (push && !full),
		.q_full     (q_full),
		.head       (head),
		.deq        (deq)
	);

	hgt_back #(.MAX_POP(MAX_POP)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.deq        (deq),
		.busy       (busy),
		.empty      (empty),
		.pop        (pop),
		.p_value    (p_value),
		.tail_sum   (tail_sum),
		.total_ways (total_ways),
		.upper_tail (upper_tail),
		.bad_query  (bad_query)
	);
endmodule
`default_nettype wire

FILE: hdl/hgt_front.sv
`default_nettype none
module hgt_front #(
	parameter int MAX_POP = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire hgt_pkg::fld_t  threshold,
	input  wire hgt_pkg::fld_t  draws,
	input  wire hgt_pkg::fld_t  successes,
	input  wire hgt_pkg::fld_t  population,
	input  wire                 accept,
	output logic                q_full,
	output hgt_pkg::hgt_q_out_t head,
	input  wire                 deq
);
	import hgt_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	hgt_desc_t             cls;
	logic [FIELD_W:0]      nm;
	logic [FIELD_W:0]      pop_w;
	fld_t                  floor_lo;
	fld_t                  min_nm;
	fld_t                  k_m1;
	logic                  upper;
	hgt_desc_t             q_mem_q [QDEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [PW:0]           count_q;

	// Classify: pick tail, then bound the index range by both stop rules.
	always_comb begin
		pop_w    = {1'b0, population};
		nm       = {1'b0, draws} + {1'b0, successes};
		floor_lo = (nm > pop_w) ? FIELD_W'(nm - pop_w) : '0;
		min_nm   = (draws < successes) ? draws : successes;
		k_m1     = threshold - FIELD_W'(1);
		upper    = ({1'b0, draws} + (FIELD_W+1)'(1)) < {threshold, 1'b0};
		cls      = '0;
		cls.bad  = (draws > population) || (successes > population)
			|| (pop_w >= (FIELD_W+1)'(MAX_POP));
		cls.upper = upper;
		cls.n    = draws;
		cls.m    = successes;
		cls.pop  = population;
		cls.lo   = floor_lo;
		cls.hi   = min_nm;
		if (upper) begin
			cls.lo = (threshold > floor_lo) ? threshold : floor_lo;
		end else if (k_m1 < min_nm) begin
			cls.hi = k_m1;
		end
		cls.none = (cls.lo > cls.hi) || (!upper && threshold == '0);
	end

	assign q_full     = (count_q == (PW+1)'(QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.desc  = q_mem_q[rd_ptr_q];

	// Hold classified items until the back takes them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				q_mem_q[wr_ptr_q] <= cls;
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (accept && !deq) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (deq && !accept) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/hgt_back.sv
`default_nettype none
`include "hypergeometric_tail_p_value_unit_macros.svh"
module hgt_back #(
	parameter int MAX_POP = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire hgt_pkg::hgt_q_out_t head,
	output logic                deq,
	output logic                busy,
	output logic                empty,
	input  wire                 pop,
	output logic [hgt_pkg::P_W-1:0]    p_value,
	output logic [hgt_pkg::COEF_W-1:0] tail_sum,
	output logic [hgt_pkg::COEF_W-1:0] total_ways,
	output logic                upper_tail,
	output logic                bad_query
);
	import hgt_pkg::*;

	localparam int DEPTH = MAX_POP * MAX_POP;
	localparam int AW    = $clog2(DEPTH);
	localparam fld_t LAST = FIELD_W'(MAX_POP - 1);

	typedef enum logic [3:0] {
		S_FILL, S_IDLE, S_RD_TOT, S_LD_TOT, S_RD_A, S_LD_A, S_LD_B,
		S_M0, S_M1, S_M2, S_ACC, S_DIVSET, S_DIV, S_DONE
	} state_t;

	function automatic logic [AW-1:0] addr_of(input fld_t r, input fld_t c);
		return AW'(32'(r) * 32'(MAX_POP) + 32'(c));
	endfunction

	state_t               state_q;
	coef_t                mem [DEPTH];
	coef_t                rdata_q;
	logic [AW-1:0]        raddr;
	// fill sweep
	fld_t                 fr_q;
	fld_t                 fc_q;
	logic                 fw_s1;
	fld_t                 fr_s1;
	fld_t                 fc_s1;
	coef_t                left_q;
	coef_t                fval;
	logic                 fill_busy_q;
	// job
	hgt_desc_t            d_q;
	fld_t                 i_q;
	coef_t                a_q;
	coef_t                b_q;
	coef_t                prod_q;
	logic [HALF_W-1:0]    cross_q;
	coef_t                sum_q;
	coef_t                tot_q;
	coef_t                rem_q;
	logic [P_W-1:0]       quo_q;
	logic [3:0]           cnt_q;
	logic [HALF_W-1:0]    mul_a;
	logic [HALF_W-1:0]    mul_b;
	logic [COEF_W-1:0]    mul_p;
	coef_t                dvd;
	logic [COEF_W:0]      shl;
	// result register
	logic                 out_valid_q;
	logic [P_W-1:0]       out_p_q;
	coef_t                out_sum_q;
	coef_t                out_tot_q;
	logic                 out_upper_q;
	logic                 out_bad_q;
	logic                 out_take;

	// Select the single read address of the store.
	always_comb begin
		unique case (state_q)
			S_FILL:   raddr = addr_of((fr_q == '0) ? '0 : fr_q - FIELD_W'(1), fc_q);
			S_RD_TOT: raddr = addr_of(d_q.pop, d_q.n);
			S_RD_A:   raddr = addr_of(d_q.m, i_q);
			default:  raddr = addr_of(d_q.pop - d_q.m, d_q.n - i_q);
		endcase
	end

	// Next Pascal entry from the row above.
	always_comb begin
		if (fc_s1 == '0) begin
			fval = COEF_W'(1);
		end else if (fc_s1 > fr_s1) begin
			fval = '0;
		end else begin
			fval = left_q + rdata_q;
		end
	end

	// Store: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (fw_s1) begin
			mem[addr_of(fr_s1, fc_s1)] <= fval;
		end
		rdata_q <= mem[raddr];
	end

	// Share one 30x30 multiplier across the three partial products.
	always_comb begin
		unique case (state_q)
			S_M0:    begin mul_a = a_q[HALF_W-1:0];       mul_b = b_q[HALF_W-1:0]; end
			S_M1:    begin mul_a = a_q[COEF_W-1:HALF_W];  mul_b = b_q[HALF_W-1:0]; end
			default: begin mul_a = a_q[HALF_W-1:0];       mul_b = b_q[COEF_W-1:HALF_W]; end
		endcase
		mul_p = COEF_W'(mul_a) * COEF_W'(mul_b);
		dvd   = d_q.upper ? sum_q : tot_q - sum_q;
		shl   = {rem_q, 1'b0};
	end

	assign out_take   = pop && out_valid_q;
	assign deq        = (state_q == S_IDLE) && head.valid;
	assign busy       = fill_busy_q;
	assign empty      = !out_valid_q;
	assign p_value    = out_p_q;
	assign tail_sum   = out_sum_q;
	assign total_ways = out_tot_q;
	assign upper_tail = out_upper_q;
	assign bad_query  = out_bad_q;

	// Sequence fill, term reads, multiply-accumulate, divide and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			fr_q        <= '0;
			fc_q        <= '0;
			fw_s1       <= 1'b0;
			fill_busy_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			fw_s1 <= 1'b0;
			if (fw_s1) begin
				left_q <= rdata_q;
				if (fr_s1 == LAST && fc_s1 == LAST) begin
					fill_busy_q <= 1'b0;
				end
			end
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_FILL: begin
					fw_s1 <= 1'b1;
					fr_s1 <= fr_q;
					fc_s1 <= fc_q;
					if (fc_q == LAST) begin
						fc_q <= '0;
						fr_q <= fr_q + FIELD_W'(1);
						if (fr_q == LAST) begin
							state_q <= S_IDLE;
						end
					end else begin
						fc_q <= fc_q + FIELD_W'(1);
					end
				end
				S_IDLE: begin
					if (head.valid && !fill_busy_q) begin
						d_q   <= head.desc;
						sum_q <= '0;
						if (head.desc.bad) begin
							tot_q   <= '0;
							quo_q   <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD_TOT;
						end
					end
				end
				S_RD_TOT: state_q <= S_LD_TOT;
				S_LD_TOT: begin
					tot_q <= rdata_q;
					i_q   <= d_q.lo;
					state_q <= d_q.none ? S_DIVSET : S_RD_A;
				end
				S_RD_A: state_q <= S_LD_A;
				S_LD_A: begin
					a_q     <= rdata_q;
					state_q <= S_LD_B;
				end
				S_LD_B: begin
					b_q     <= rdata_q;
					state_q <= S_M0;
				end
				S_M0: begin
					prod_q  <= mul_p;
					state_q <= S_M1;
				end
				S_M1: begin
					cross_q <= mul_p[HALF_W-1:0];
					state_q <= S_M2;
				end
				S_M2: begin
					cross_q <= cross_q + mul_p[HALF_W-1:0];
					state_q <= S_ACC;
				end
				S_ACC: begin
					sum_q <= sum_q + prod_q + {cross_q, {HALF_W{1'b0}}};
					if (i_q == d_q.hi) begin
						state_q <= S_DIVSET;
					end else begin
						i_q     <= i_q + FIELD_W'(1);
						state_q <= S_RD_A;
					end
				end
				S_DIVSET: begin
					rem_q <= dvd;
					quo_q <= '0;
					cnt_q <= 4'(FRAC_BITS - 1);
					if (!d_q.upper && sum_q >= tot_q) begin
						state_q <= S_DONE;
					end else if (tot_q == '0 || dvd >= tot_q) begin
						quo_q   <= ONE_FIXED;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (shl >= {1'b0, tot_q}) begin
						rem_q <= COEF_W'(shl - {1'b0, tot_q});
						quo_q <= {quo_q[P_W-2:0], 1'b1};
					end else begin
						rem_q <= shl[COEF_W-1:0];
						quo_q <= {quo_q[P_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_take) begin
						out_valid_q <= 1'b1;
						out_p_q     <= quo_q;
						out_sum_q   <= sum_q;
						out_tot_q   <= tot_q;
						out_upper_q <= d_q.upper && !d_q.bad;
						out_bad_q   <= d_q.bad;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HGT_NEVER(a_no_result_in_fill, clk, arst_n, fill_busy_q && out_valid_q)
	`HGT_ASSERT(a_bad_all_zero, clk, arst_n, out_valid_q && out_bad_q |-> out_p_q == '0 && out_sum_q == '0 && out_tot_q == '0 && !out_upper_q)
	`HGT_ASSERT(a_p_bounded, clk, arst_n, out_valid_q |-> out_p_q <= ONE_FIXED)
endmodule
`default_nettype wire
